// ----- rtl/sct_pkg.sv -----
// Package: shared types, codes and classification helpers for the tokenizer.
package sct_pkg;

   localparam int KeywordChars = 9;
   localparam int WlenWidth = $clog2(KeywordChars + 2);
   localparam int FifoDepth = 4;
   localparam int FifoAw = $clog2(FifoDepth);

   localparam logic [5:0] K_EOF    = 6'd0;
   localparam logic [5:0] K_STRING = 6'd32;
   localparam logic [5:0] K_NUMBER = 6'd33;
   localparam logic [5:0] K_IDENT  = 6'd34;
   localparam logic [5:0] K_KW0    = 6'd35;
   localparam logic [5:0] K_ERROR  = 6'd44;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_OPER, MODE_IDENT, MODE_NUMBER, MODE_STRING,
      MODE_ESCAPE, MODE_LINE, MODE_BLOCK, MODE_BLOCK_STAR
   } mode_type;

   // byte classification computed by the front end
   typedef struct packed {
      logic [7:0] c;
      logic       is_space;
      logic       is_alpha;
      logic       is_digit;
      logic [5:0] single;
      logic [5:0] starter;
   } cls_type;

   typedef struct packed {
      logic [5:0] kind;
      logic [7:0] text;
      logic       tv;
      logic       done;
      logic       last;
   } rsp_type;

   function automatic logic [5:0] single_kind(input logic [7:0] c);
      case (c)
         ";": single_kind = 6'd1;   ",": single_kind = 6'd2;
         ".": single_kind = 6'd3;   "^": single_kind = 6'd10;
         "(": single_kind = 6'd25;  ")": single_kind = 6'd26;
         "[": single_kind = 6'd27;  "]": single_kind = 6'd28;
         "{": single_kind = 6'd29;  "}": single_kind = 6'd30;
         ":": single_kind = 6'd31;
         default: single_kind = 6'd0;
      endcase
   endfunction

   function automatic logic [5:0] starter_kind(input logic [7:0] c);
      case (c)
         "=": starter_kind = 6'd4;   "&": starter_kind = 6'd6;
         "|": starter_kind = 6'd8;   "!": starter_kind = 6'd11;
         "+": starter_kind = 6'd13;  "-": starter_kind = 6'd15;
         "*": starter_kind = 6'd17;  "/": starter_kind = 6'd19;
         "<": starter_kind = 6'd21;  ">": starter_kind = 6'd23;
         default: starter_kind = 6'd0;
      endcase
   endfunction

endpackage

// ----- rtl/sct_front.sv -----
// Front end: input register and byte classification.
module sct_front import sct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   output logic       cls_valid,
   input  logic       cls_ready,
   output cls_type    cls
);
   logic    valid_ff, valid_in;
   cls_type cls_ff, cls_in;

   assign in_ready = !valid_ff || cls_ready;
   assign cls_valid = valid_ff;
   assign cls = cls_ff;

   always_comb begin
      cls_in.c        = in_byte;
      cls_in.is_space = (in_byte == 8'h20) || (in_byte >= 8'd9 && in_byte <= 8'd13);
      cls_in.is_alpha = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z");
      cls_in.is_digit = in_byte >= "0" && in_byte <= "9";
      cls_in.single   = single_kind(in_byte);
      cls_in.starter  = starter_kind(in_byte);
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (in_valid && in_ready) cls_ff <= cls_in;
   end
endmodule

// ----- rtl/sct_back.sv -----
// Back end: lexer state machine producing up to two results per byte.
module sct_back import sct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cls_valid,
   output logic    cls_ready,
   input  cls_type cls,
   output logic    push,
   output rsp_type push_data [3],
   output logic [1:0] push_count,
   input  logic [FifoAw:0] fifo_free
);
   mode_type   mode_ff, mode_in;
   logic [7:0] pend_ff, pend_in;
   logic [WlenWidth-1:0] wlen_ff, wlen_in;
   logic [7:0] kwbuf_ff [KeywordChars];
   logic       kw_we;
   logic [7:0] c;
   rsp_type    r [3];
   logic [1:0] n;
   logic [5:0] wkind, pk;
   logic       is_word;

   assign c = cls.c;
   assign cls_ready = fifo_free >= (FifoAw+1)'(3);
   assign push = cls_valid && cls_ready;
   assign is_word = cls.is_alpha || cls.is_digit || c == "_";

   function automatic logic kw_match(input logic [7:0] b [KeywordChars],
                                     input logic [WlenWidth-1:0] len,
                                     input logic [8*KeywordChars-1:0] s,
                                     input int l);
      logic ok;
      ok = (len == WlenWidth'(l));
      for (int i = 0; i < KeywordChars; i++)
         if (i < l && b[i] != s[8*(l-1-i) +: 8]) ok = 1'b0;
      return ok;
   endfunction

   always_comb begin
      wkind = K_IDENT;
      if      (kw_match(kwbuf_ff, wlen_ff, 72'("type"), 4))      wkind = K_KW0;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("if"), 2))        wkind = K_KW0 + 6'd1;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("ifn"), 3))       wkind = K_KW0 + 6'd2;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("int8"), 4))      wkind = K_KW0 + 6'd3;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("else"), 4))      wkind = K_KW0 + 6'd4;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("for"), 3))       wkind = K_KW0 + 6'd5;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("while"), 5))     wkind = K_KW0 + 6'd6;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("return"), 6))    wkind = K_KW0 + 6'd7;
      else if (kw_match(kwbuf_ff, wlen_ff, 72'("namespace"), 9)) wkind = K_KW0 + 6'd8;
   end

   function automatic rsp_type mk(input logic [5:0] k, input logic [7:0] t, input logic tv,
                                  input logic d);
      rsp_type x;
      x.kind = k; x.text = t; x.tv = tv; x.done = d; x.last = 1'b0;
      return x;
   endfunction

   always_comb begin
      logic idle_pass;
      idle_pass = 1'b0;
      mode_in = mode_ff;
      pend_in = pend_ff;
      wlen_in = wlen_ff;
      kw_we = 1'b0;
      n = 2'd0;
      for (int i = 0; i < 3; i++) r[i] = mk(K_EOF, 8'd0, 1'b0, 1'b0);
      pk = starter_kind(pend_ff);
      unique case (mode_ff)
         MODE_OPER: begin
            pend_in = 8'd0;
            mode_in = MODE_IDLE;
            if (pend_ff == "/" && c == "/") mode_in = MODE_LINE;
            else if (pend_ff == "/" && c == "*") mode_in = MODE_BLOCK;
            else if (pk != 6'd0 && c == ((pend_ff == "&" || pend_ff == "|") ? pend_ff : 8'h3d)) begin
               r[0] = mk(pk + 6'd1, 8'd0, 1'b0, 1'b1); n = 2'd1;
            end else begin
               r[0] = mk((pk != 6'd0) ? pk : K_ERROR, 8'd0, 1'b0, 1'b1); n = 2'd1;
               idle_pass = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_word) begin
               if (wlen_ff < WlenWidth'(KeywordChars)) begin
                  kw_we = 1'b1; wlen_in = wlen_ff + 1'b1;
               end else wlen_in = WlenWidth'(KeywordChars + 1);
               r[0] = mk(K_IDENT, c, 1'b1, 1'b0); n = 2'd1;
            end else begin
               r[0] = mk(wkind, 8'd0, 1'b0, 1'b1); n = 2'd1; idle_pass = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (cls.is_digit || c == ".") begin
               r[0] = mk(K_NUMBER, c, 1'b1, 1'b0); n = 2'd1;
            end else begin
               r[0] = mk(K_NUMBER, 8'd0, 1'b0, 1'b1); n = 2'd1; idle_pass = 1'b1;
            end
         end
         MODE_STRING: begin
            if (c == 8'h22) begin
               r[0] = mk(K_STRING, 8'd0, 1'b0, 1'b1); n = 2'd1; mode_in = MODE_IDLE;
            end else if (c == 8'h5c) mode_in = MODE_ESCAPE;
            else if (c == 8'd0) begin
               r[0] = mk(K_ERROR, 8'd0, 1'b0, 1'b1); r[1] = mk(K_EOF, 8'd0, 1'b0, 1'b1);
               n = 2'd2; mode_in = MODE_IDLE;
            end else begin
               r[0] = mk(K_STRING, c, 1'b1, 1'b0); n = 2'd1;
            end
         end
         MODE_ESCAPE: begin
            mode_in = MODE_STRING;
            n = 2'd1;
            case (c)
               "n": r[0] = mk(K_STRING, 8'h0a, 1'b1, 1'b0);
               "t": r[0] = mk(K_STRING, 8'h09, 1'b1, 1'b0);
               8'h22: r[0] = mk(K_STRING, 8'h22, 1'b1, 1'b0);
               8'h5c: r[0] = mk(K_STRING, 8'h5c, 1'b1, 1'b0);
               "v": r[0] = mk(K_STRING, 8'h0b, 1'b1, 1'b0);
               "r": r[0] = mk(K_STRING, 8'h0d, 1'b1, 1'b0);
               "f": r[0] = mk(K_STRING, 8'h0c, 1'b1, 1'b0);
               "0": r[0] = mk(K_STRING, 8'h00, 1'b1, 1'b0);
               8'd0: begin
                  r[0] = mk(K_ERROR, 8'd0, 1'b0, 1'b1); r[1] = mk(K_EOF, 8'd0, 1'b0, 1'b1);
                  n = 2'd2; mode_in = MODE_IDLE;
               end
               default: n = 2'd0;
            endcase
         end
         MODE_LINE: begin
            if (c == 8'h0a) mode_in = MODE_IDLE;
            else if (c == 8'd0) idle_pass = 1'b1;
         end
         MODE_BLOCK, MODE_BLOCK_STAR: begin
            if (c == 8'd0) idle_pass = 1'b1;
            else if (mode_ff == MODE_BLOCK_STAR && c == "/") mode_in = MODE_IDLE;
            else mode_in = (c == "*") ? MODE_BLOCK_STAR : MODE_BLOCK;
         end
         default: idle_pass = 1'b1;
      endcase

      if (idle_pass) begin
         mode_in = MODE_IDLE;
         if (c == 8'd0) begin
            r[n] = mk(K_EOF, 8'd0, 1'b0, 1'b1); n = n + 2'd1;
         end else if (cls.is_space) begin
         end else if (cls.single != 6'd0) begin
            r[n] = mk(cls.single, 8'd0, 1'b0, 1'b1); n = n + 2'd1;
         end else if (cls.starter != 6'd0) begin
            mode_in = MODE_OPER; pend_in = c;
         end else if (c == 8'h22) mode_in = MODE_STRING;
         else if (cls.is_alpha || c == "_") begin
            mode_in = MODE_IDENT; wlen_in = WlenWidth'(1); kw_we = 1'b1;
            r[n] = mk(K_IDENT, c, 1'b1, 1'b0); n = n + 2'd1;
         end else if (cls.is_digit) begin
            mode_in = MODE_NUMBER;
            r[n] = mk(K_NUMBER, c, 1'b1, 1'b0); n = n + 2'd1;
         end else begin
            r[n] = mk(K_ERROR, 8'd0, 1'b0, 1'b1); n = n + 2'd1;
         end
      end
      if (n != 2'd0) r[n - 2'd1].last = 1'b1;
      for (int i = 0; i < 3; i++) push_data[i] = r[i];
      push_count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         pend_ff <= 8'd0;
         wlen_ff <= '0;
      end else if (push) begin
         mode_ff <= mode_in;
         pend_ff <= pend_in;
         wlen_ff <= wlen_in;
      end
      // new word always restarts at entry 0 (wlen_in is 1 then)
      if (push && kw_we) kwbuf_ff[wlen_in[$clog2(KeywordChars)-1:0] - 1'b1] <= c;
   end

   a_wlen_bound: assert property (@(posedge clock) disable iff (reset)
      wlen_ff <= WlenWidth'(KeywordChars + 1)) else $error("word length overflow");
   a_pend_oper: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_OPER |-> starter_kind(pend_ff) != 6'd0) else $error("bad pending op");
   a_room: assert property (@(posedge clock) disable iff (reset)
      push |-> fifo_free >= (FifoAw+1)'(push_count)) else $error("queue overrun");
endmodule

// ----- rtl/sct_queue.sv -----
// Result queue: accepts up to three results a cycle, delivers one.
module sct_queue import sct_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data [3],
   input  logic [1:0] push_count,
   output logic [FifoAw:0] fifo_free,
   output logic       out_valid,
   input  logic       out_ready,
   output rsp_type    out_data
);
   rsp_type mem_ff [FifoDepth];
   logic [FifoAw-1:0] wp_ff, rp_ff;
   logic [FifoAw:0]   cnt_ff, cnt_in;
   logic pop;

   assign out_valid = cnt_ff != '0;
   assign out_data = mem_ff[rp_ff];
   assign pop = out_valid && out_ready;
   assign fifo_free = (FifoAw+1)'(FifoDepth) - cnt_ff;

   always_comb begin
      cnt_in = cnt_ff - (FifoAw+1)'(pop);
      if (push) cnt_in = cnt_in + (FifoAw+1)'(push_count);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (pop) rp_ff <= rp_ff + 1'b1;
         if (push) wp_ff <= wp_ff + FifoAw'(push_count);
      end
      if (push)
         for (int i = 0; i < 3; i++)
            if (2'(i) < push_count) mem_ff[wp_ff + FifoAw'(i)] <= push_data[i];
   end

   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (FifoAw+1)'(FifoDepth)) else $error("queue count");
   a_ptr: assert property (@(posedge clock) disable iff (reset)
      FifoAw'(wp_ff - rp_ff) == cnt_ff[FifoAw-1:0]) else $error("queue pointers");
endmodule

// ----- rtl/source_code_tokenizer_unit.sv -----
// Top level: streaming source tokenizer.
// Usage:
//  - req_ channel carries one source byte per transfer; byte 0 ends the
//    source and always yields an eof token, then the lexer returns to idle.
//  - rsp_ channel carries result transfers; each input byte gives 0 to 2
//    results, and the last one of a byte carries rsp_tlast.
//  - Throughput is one byte per cycle while the result queue has room for
//    three results; set by the 4-entry queue between lexer and output.
//  - A byte's first result passes the input register, then the lexer
//    writes it into the queue, where the output reads it.
//  - Word text streams as identifier (34); the closing result gives the
//    final keyword or identifier kind, decided from a 9-byte word buffer.
//  - When rsp_tready is low the queue fills and req_tready drops; nothing
//    is lost. Reset (synchronous) empties the queue, lexer goes idle.
module source_code_tokenizer_unit import sct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] source_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [5:0] token_kind, [13:6] text_byte, [15:14] zero
   output logic [1:0]  rsp_tuser,   // [0] text_valid, [1] token_done
   output logic        rsp_tlast
);
   logic       cls_valid, cls_ready, push;
   cls_type    cls;
   rsp_type    push_data [3];
   rsp_type    out_data;
   logic [1:0] push_count;
   logic [FifoAw:0] fifo_free;

   sct_front u_front (
      .clock, .reset, .in_valid(req_tvalid), .in_ready(req_tready), .in_byte(req_tdata),
      .cls_valid, .cls_ready, .cls
   );

   sct_back u_back (
      .clock, .reset, .cls_valid, .cls_ready, .cls, .push, .push_data, .push_count,
      .fifo_free
   );

   sct_queue u_queue (
      .clock, .reset, .push, .push_data, .push_count, .fifo_free,
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data
   );

   assign rsp_tdata = {2'b00, out_data.text, out_data.kind};
   assign rsp_tuser = {out_data.done, out_data.tv};
   assign rsp_tlast = out_data.last;
endmodule
